### rtl/core/gmrf_pkg.sv
// Shared constants, register codes and types of the grid MRF energy evaluator.
`timescale 1ns / 1ps
package gmrf_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned PIXEL_BITS_DEF = 8;

    localparam int unsigned GEOM_W       = 11;
    localparam int unsigned ROW_W        = 10;
    localparam int unsigned TRUNC_W      = 16;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned DATA_SUM_W   = 28;
    localparam int unsigned SMOOTH_SUM_W = 37;
    localparam int unsigned OUT_BITS     = DATA_SUM_W + 2 * SMOOTH_SUM_W;
    localparam int unsigned M_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int unsigned M_PAD_W      = M_TDATA_W - OUT_BITS;

    localparam logic [GEOM_W-1:0] MAX_HEIGHT = GEOM_W'(1024);

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_FRAME_WIDTH  = 2'd0;
    localparam t_cfg_index CFG_FRAME_HEIGHT = 2'd1;
    localparam t_cfg_index CFG_TRUNCATION   = 2'd2;
    localparam t_cfg_index CFG_COST_MODE    = 2'd3;

    localparam logic [GEOM_W-1:0]  RST_FRAME_WIDTH  = GEOM_W'(1024);
    localparam logic [GEOM_W-1:0]  RST_FRAME_HEIGHT = GEOM_W'(1024);
    localparam logic [TRUNC_W-1:0] RST_TRUNCATION   = TRUNC_W'(65025);
    localparam logic               RST_COST_MODE    = 1'b0;

    typedef struct packed {
        logic               squared;
        logic [TRUNC_W-1:0] truncation;
    } t_cost_cfg;

endpackage

### rtl/core/gmrf_pair_cost.sv
// Truncated absolute or squared difference between two labels.
`timescale 1ns / 1ps
module gmrf_pair_cost #(
    parameter int unsigned PIXEL_BITS = gmrf_pkg::PIXEL_BITS_DEF
) (
    input  logic [PIXEL_BITS-1:0]        i_a,
    input  logic [PIXEL_BITS-1:0]        i_b,
    input  gmrf_pkg::t_cost_cfg          i_cfg,
    output logic [gmrf_pkg::TRUNC_W-1:0] o_cost
);

    localparam int unsigned PROD_W = 2 * PIXEL_BITS;
    localparam int unsigned CMP_W  = (PROD_W > gmrf_pkg::TRUNC_W) ? PROD_W : gmrf_pkg::TRUNC_W;

    logic [PIXEL_BITS-1:0] diff;
    logic [PROD_W-1:0]     square;
    logic [CMP_W-1:0]      raw;
    logic [CMP_W-1:0]      limit;

    always_comb begin
        diff   = (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);
        square = PROD_W'(diff) * PROD_W'(diff);
        raw    = i_cfg.squared ? CMP_W'(square) : CMP_W'(diff);
        limit  = CMP_W'(i_cfg.truncation);
        o_cost = (raw < limit) ? gmrf_pkg::TRUNC_W'(raw) : i_cfg.truncation;
    end

endmodule

### rtl/core/grid_mrf_energy_evaluator_top.sv
// Top level of the grid MRF energy evaluator: raster pixel stream in, frame energy out.
`timescale 1ns / 1ps
// Pixels enter on the slave stream in raster order, one beat per pixel, and the
// block accumulates the data cost and the truncated pairwise cost of the labeling
// against the left and upper neighbors. The previous row of labels lives in a
// one-port-read, one-port-write memory of MAX_WIDTH entries that is read and
// rewritten at the same address in the cycle a pixel is accepted.
// One pixel is accepted every cycle while the pipeline is not held. The beat of
// the last pixel of a frame produces one master beat with the data sum, the
// smoothness sum and the total via stages r1, r2, r3 and the output register.
// Other pixels produce no beat. The sums saturate and clear after each frame.
// Configuration writes take effect at once; the user must make them only while
// no pixel is in flight, as the block does not enforce this. Width and height
// are clamped to 1..MAX_WIDTH and 1..1024. Reset clears the raster position,
// sums, left label and configuration, not the row memory, unused on the top row.
// While a result waits on the master side with tready low, pixels keep flowing
// until the next finished frame reaches the stage behind the output register;
// then the whole pipeline holds and the slave tready is low.
module grid_mrf_energy_evaluator_top #(
    parameter int unsigned MAX_WIDTH  = gmrf_pkg::MAX_WIDTH_DEF,
    parameter int unsigned PIXEL_BITS = gmrf_pkg::PIXEL_BITS_DEF,
    localparam int unsigned S_TDATA_W = ((2 * PIXEL_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  gmrf_pkg::t_cfg_index            i_cfg_index,
    input  logic [gmrf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // observed_value, pixel_label
    input  logic [S_TDATA_W-1:0]            i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // data_sum, smooth_sum, total_energy
    output logic [gmrf_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    localparam int unsigned AW  = $clog2(MAX_WIDTH);
    localparam int unsigned WW  = (AW + 1 > gmrf_pkg::GEOM_W) ? AW + 1 : gmrf_pkg::GEOM_W;
    localparam int unsigned TW  = gmrf_pkg::TRUNC_W;
    localparam int unsigned DW  = gmrf_pkg::DATA_SUM_W;
    localparam int unsigned SW  = gmrf_pkg::SMOOTH_SUM_W;
    localparam int unsigned GW  = gmrf_pkg::GEOM_W;
    localparam int unsigned RW  = gmrf_pkg::ROW_W;
    localparam logic [DW-1:0] DATA_MAX   = '1;
    localparam logic [SW-1:0] SMOOTH_MAX = '1;

    logic [GW-1:0] r_cfg_width;
    logic [GW-1:0] r_cfg_height;
    logic [TW-1:0] r_cfg_trunc;
    logic          r_cfg_mode;

    logic [PIXEL_BITS-1:0] mem_row [MAX_WIDTH];

    logic [AW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic [PIXEL_BITS-1:0] r_left;

    logic                  r1_valid;
    logic [PIXEL_BITS-1:0] r1_lab;
    logic [PIXEL_BITS-1:0] r1_obs;
    logic [PIXEL_BITS-1:0] r1_left;
    logic [PIXEL_BITS-1:0] r1_up;
    logic                  r1_has_left;
    logic                  r1_has_up;
    logic                  r1_last;

    logic                  r2_valid;
    logic [PIXEL_BITS-1:0] r2_dcost;
    logic [TW-1:0]         r2_lcost;
    logic [TW-1:0]         r2_ucost;
    logic                  r2_last;

    logic [DW-1:0] r_data_acc;
    logic [SW-1:0] r_smooth_acc;
    logic [DW-1:0] n_data_acc;
    logic [SW-1:0] n_smooth_acc;

    logic          r3_valid;
    logic [DW-1:0] r3_data;
    logic [SW-1:0] r3_smooth;

    logic          r_o_valid;
    logic [DW-1:0] r_o_data;
    logic [SW-1:0] r_o_smooth;
    logic [SW-1:0] r_o_total;

    logic                  o_load;
    logic                  en;
    logic                  accept;
    logic [PIXEL_BITS-1:0] in_obs;
    logic [PIXEL_BITS-1:0] in_lab;
    logic [WW-1:0]         cfg_w;
    logic [WW-1:0]         w_eff;
    logic [GW-1:0]         h_eff;
    logic                  end_row;
    logic                  end_frame;
    logic [TW-1:0]         cost_left;
    logic [TW-1:0]         cost_up;
    logic [PIXEL_BITS-1:0] data_cost;
    logic [DW:0]           data_sum;
    logic [TW:0]           pair_sum;
    logic [SW:0]           smooth_sum;
    logic [SW:0]           total_sum;
    gmrf_pkg::t_cost_cfg   cost_cfg;

    assign o_load     = !r_o_valid || i_m_tready;
    assign en         = o_load || !r3_valid;
    assign o_s_tready = en;
    assign accept     = i_s_tvalid && en;
    assign in_obs     = i_s_tdata[PIXEL_BITS-1:0];
    assign in_lab     = i_s_tdata[2*PIXEL_BITS-1:PIXEL_BITS];

    always_comb begin
        cfg_w = WW'(r_cfg_width);
        if (cfg_w == '0) begin
            w_eff = WW'(1);
        end else if (cfg_w > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = cfg_w;
        end
        if (r_cfg_height == '0) begin
            h_eff = GW'(1);
        end else if (r_cfg_height > gmrf_pkg::MAX_HEIGHT) begin
            h_eff = gmrf_pkg::MAX_HEIGHT;
        end else begin
            h_eff = r_cfg_height;
        end
        end_row   = (WW'(r_col) + WW'(1)) >= w_eff;
        end_frame = end_row && ((GW'(r_row) + GW'(1)) >= h_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= gmrf_pkg::RST_FRAME_WIDTH;
            r_cfg_height <= gmrf_pkg::RST_FRAME_HEIGHT;
            r_cfg_trunc  <= gmrf_pkg::RST_TRUNCATION;
            r_cfg_mode   <= gmrf_pkg::RST_COST_MODE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gmrf_pkg::CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data[GW-1:0];
                gmrf_pkg::CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data[GW-1:0];
                gmrf_pkg::CFG_TRUNCATION:   r_cfg_trunc  <= i_cfg_data[TW-1:0];
                gmrf_pkg::CFG_COST_MODE:    r_cfg_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_up          <= mem_row[r_col];
            mem_row[r_col] <= in_lab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= '0;
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= accept;
            if (accept) begin
                if (end_frame) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_left <= '0;
                end else begin
                    r_left <= in_lab;
                    if (end_row) begin
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                    end else begin
                        r_col <= r_col + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_lab      <= in_lab;
            r1_obs      <= in_obs;
            r1_left     <= r_left;
            r1_has_left <= (r_col != '0);
            r1_has_up   <= (r_row != '0);
            r1_last     <= end_frame;
        end
    end

    assign cost_cfg.squared    = r_cfg_mode;
    assign cost_cfg.truncation = r_cfg_trunc;
    assign data_cost = (r1_lab > r1_obs) ? (r1_lab - r1_obs) : (r1_obs - r1_lab);

    gmrf_pair_cost #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_cost_left (
        .i_a    (r1_lab),
        .i_b    (r1_left),
        .i_cfg  (cost_cfg),
        .o_cost (cost_left)
    );

    gmrf_pair_cost #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_cost_up (
        .i_a    (r1_lab),
        .i_b    (r1_up),
        .i_cfg  (cost_cfg),
        .o_cost (cost_up)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r1_valid) begin
            r2_dcost <= data_cost;
            r2_lcost <= r1_has_left ? cost_left : '0;
            r2_ucost <= r1_has_up ? cost_up : '0;
            r2_last  <= r1_last;
        end
    end

    always_comb begin
        data_sum     = (DW + 1)'(r_data_acc) + (DW + 1)'(r2_dcost);
        n_data_acc   = data_sum[DW] ? DATA_MAX : data_sum[DW-1:0];
        pair_sum     = (TW + 1)'(r2_lcost) + (TW + 1)'(r2_ucost);
        smooth_sum   = (SW + 1)'(r_smooth_acc) + (SW + 1)'(pair_sum);
        n_smooth_acc = smooth_sum[SW] ? SMOOTH_MAX : smooth_sum[SW-1:0];
        total_sum    = (SW + 1)'(r3_data) + (SW + 1)'(r3_smooth);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_acc   <= '0;
            r_smooth_acc <= '0;
            r3_valid     <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid && r2_last;
            if (r2_valid) begin
                if (r2_last) begin
                    r_data_acc   <= '0;
                    r_smooth_acc <= '0;
                end else begin
                    r_data_acc   <= n_data_acc;
                    r_smooth_acc <= n_smooth_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r2_valid && r2_last) begin
            r3_data   <= n_data_acc;
            r3_smooth <= n_smooth_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && r3_valid) begin
            r_o_data   <= r3_data;
            r_o_smooth <= r3_smooth;
            r_o_total  <= total_sum[SW] ? SMOOTH_MAX : total_sum[SW-1:0];
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{gmrf_pkg::M_PAD_W{1'b0}}, r_o_total, r_o_smooth, r_o_data};

    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r2_valid && r2_last) |=> (r_data_acc == '0 && r_smooth_acc == '0))
        else $error("Sums not cleared after the last pixel of a frame.");

    a_smooth_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r2_valid && !r2_last) |=> (r_smooth_acc >= $past(r_smooth_acc)))
        else $error("Smoothness sum decreased within a frame.");

    a_result_from_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r3_valid))
        else $error("Result beat without a finished frame.");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && !en) |=> (r1_valid && $stable(r1_lab) && $stable(r1_up)))
        else $error("First stage lost a pixel during a stall.");

endmodule
